// ===== sv/apn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apn_pkg
// Shared types and constants of the audio peak normalizer.
// ----------------------------------------------------------------------------
package apn_pkg;

    localparam int SampleW  = 16;
    localparam int PeakW    = 15;
    localparam int TargetW  = 16;
    localparam int ScaledW  = 32;

    localparam logic [TargetW-1:0] TargetReset = 16'd36773;

    // job queue between the front and the back
    localparam int QDepth   = 2;
    localparam int QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntW    = $clog2(QDepth + 1);

    localparam logic OpMeasure = 1'b0;
    localparam logic OpScale   = 1'b1;

    // divide steps, one quotient bit each
    localparam int DivSteps = ScaledW;
    localparam int DivCntW  = $clog2(DivSteps);

    // one scale job: sample plus the peak in force when it was accepted
    typedef struct packed {
        logic signed [SampleW-1:0] sample;
        logic [PeakW-1:0]          peak;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

// ===== sv/apn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apn_front
// Accepts input transactions, tracks the measure-pass peak and hands scale
// samples to the job queue together with the current peak.
// ----------------------------------------------------------------------------
module apn_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic                          i_first,
    input  logic signed [apn_pkg::SampleW-1:0] i_sample,
    input  logic                          i_q_full,
    output logic                          o_push,
    output apn_pkg::t_job                 o_job
);

    logic [apn_pkg::PeakW-1:0] r_peak;
    logic [apn_pkg::PeakW-1:0] n_peak;
    logic [apn_pkg::PeakW-1:0] base;
    logic                      accept;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        base   = i_first ? '0 : r_peak;
        n_peak = r_peak;
        if (accept && (i_op == apn_pkg::OpMeasure)) begin
            n_peak = base;
            // only positive samples can raise the peak
            if (!i_sample[apn_pkg::SampleW-1] && (i_sample[apn_pkg::PeakW-1:0] > base)) begin
                n_peak = i_sample[apn_pkg::PeakW-1:0];
            end
        end
    end

    assign o_push       = accept && (i_op == apn_pkg::OpScale);
    assign o_job.sample = i_sample;
    assign o_job.peak   = r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else begin
            r_peak <= n_peak;
        end
    end

endmodule

// ===== sv/apn_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apn_queue
// Short job queue decoupling the front from the divide engine.
// ----------------------------------------------------------------------------
module apn_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  apn_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output apn_pkg::t_job o_job
);

    apn_pkg::t_job                r_mem [apn_pkg::QDepth];
    logic [apn_pkg::QPtrW-1:0]    r_wr_ptr;
    logic [apn_pkg::QPtrW-1:0]    r_rd_ptr;
    logic [apn_pkg::QCntW-1:0]    r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_count == apn_pkg::QCntW'(apn_pkg::QDepth));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [apn_pkg::QPtrW-1:0] ptr_inc(input logic [apn_pkg::QPtrW-1:0] p);
        logic [apn_pkg::QPtrW-1:0] r;
        if (p == apn_pkg::QPtrW'(apn_pkg::QDepth - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/apn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apn_back
// Scale engine: magnitude times target, then a restoring divide by the peak,
// one quotient bit per cycle, sign restored at the end; a zero peak skips both
// and gives 0. Holds the result in an output register.
// ----------------------------------------------------------------------------
module apn_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [apn_pkg::TargetW-1:0]        i_target,
    input  logic                               i_q_valid,
    input  apn_pkg::t_job                      i_job,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [apn_pkg::ScaledW-1:0] o_scaled,
    output logic                               o_zero_peak
);

    apn_pkg::t_back_state            r_state;
    apn_pkg::t_back_state            n_state;
    logic [apn_pkg::SampleW-1:0]     r_mag;
    logic                            r_neg;
    logic                            r_zero;
    logic [apn_pkg::PeakW-1:0]       r_pk;
    logic [apn_pkg::PeakW-1:0]       r_rem;
    logic [apn_pkg::ScaledW-1:0]     r_quo;
    logic [apn_pkg::DivCntW-1:0]     r_cnt;
    logic                            r_out_valid;
    logic signed [apn_pkg::ScaledW-1:0] r_scaled;
    logic                            r_zero_peak;

    logic [apn_pkg::SampleW-1:0]     mag;
    logic [apn_pkg::PeakW:0]         trial;
    logic                            q_bit;
    logic [apn_pkg::PeakW-1:0]       rem_next;
    logic                            out_free;
    logic                            load_out;
    logic                            div_last;

    // magnitude of the incoming sample; -32768 maps to 32768
    assign mag = i_job.sample[apn_pkg::SampleW-1] ? (~i_job.sample + 1'b1) : i_job.sample;

    always_comb begin
        trial    = {r_rem, r_quo[apn_pkg::ScaledW-1]};
        q_bit    = (trial >= {1'b0, r_pk});
        rem_next = q_bit ? apn_pkg::PeakW'(trial - {1'b0, r_pk})
                         : trial[apn_pkg::PeakW-1:0];
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign div_last = (r_cnt == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            apn_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_job.peak == '0) ? apn_pkg::ST_DONE : apn_pkg::ST_MUL;
                end
            end
            apn_pkg::ST_MUL: begin
                n_state = apn_pkg::ST_DIV;
            end
            apn_pkg::ST_DIV: begin
                if (div_last) begin
                    n_state = apn_pkg::ST_DONE;
                end
            end
            apn_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = apn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = apn_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            apn_pkg::ST_IDLE: o_pop    = i_q_valid;
            apn_pkg::ST_DONE: load_out = out_free;
            default: begin
                o_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mag  <= mag;
            r_neg  <= i_job.sample[apn_pkg::SampleW-1];
            r_pk   <= i_job.peak;
            r_zero <= (i_job.peak == '0);
            r_quo  <= '0;
        end else if (r_state == apn_pkg::ST_MUL) begin
            r_quo <= apn_pkg::ScaledW'(r_mag * i_target);
            r_rem <= '0;
            r_cnt <= apn_pkg::DivCntW'(apn_pkg::DivSteps - 1);
        end else if (r_state == apn_pkg::ST_DIV) begin
            r_quo <= {r_quo[apn_pkg::ScaledW-2:0], q_bit};
            r_rem <= rem_next;
            r_cnt <= r_cnt - 1'b1;
        end
        if (load_out) begin
            r_scaled    <= r_neg ? -$signed(r_quo) : $signed(r_quo);
            r_zero_peak <= r_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= apn_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scaled    = r_scaled;
    assign o_zero_peak = r_zero_peak;

endmodule

// ===== sv/audio_peak_normalizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_peak_normalizer
// Two-pass peak normalizer for signed 16-bit audio.
//
// Input channel (i_in_valid / o_in_stall): op 0 samples are the measure pass
// and update the peak at once, producing nothing; first restarts the peak.
// op 1 samples are the scale pass and each produces one output transaction
// (o_out_valid / i_out_stall): sample * target_peak / peak, truncated toward
// zero, or 0 with o_zero_peak set when the peak is zero.
// Scale samples enter a 2-entry job queue holding the peak seen at accept.
// The back end works on one scale sample at a time, in order: a pop, a
// multiply, 32 restoring divide steps (one quotient bit each) and an output
// load; the queue can take new jobs while it is busy. Measure samples are
// accepted whenever the queue is not full. Zero-peak samples skip the
// multiply and the divide and go from the pop straight to the output load.
// target_peak resets to 36773 and is written with i_cfg_we; the user must write it only while idle (not enforced).
// Reset (synchronous, active low) clears the peak, queue and output valid.
// While the receiver stalls the result holds; the engine finishes the next
// job and waits, and o_in_stall rises once the queue fills.
// ----------------------------------------------------------------------------
module audio_peak_normalizer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [apn_pkg::TargetW-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_op,
    input  logic                               i_first,
    input  logic signed [apn_pkg::SampleW-1:0] i_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [apn_pkg::ScaledW-1:0] o_scaled,
    output logic                               o_zero_peak
);

    logic [apn_pkg::TargetW-1:0] r_target;
    logic                        q_full;
    logic                        q_push;
    logic                        q_pop;
    logic                        q_valid;
    apn_pkg::t_job               push_job;
    apn_pkg::t_job               head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= apn_pkg::TargetReset;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_data;
        end
    end

    apn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_op       (i_op),
        .i_first    (i_first),
        .i_sample   (i_sample),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    apn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    apn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_target    (r_target),
        .i_q_valid   (q_valid),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_scaled    (o_scaled),
        .o_zero_peak (o_zero_peak)
    );

endmodule

// ===== sv/apn_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apn_checker
// Port-level checks for the audio peak normalizer.
// ----------------------------------------------------------------------------
module apn_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic signed [apn_pkg::ScaledW-1:0] o_scaled,
    input logic                               o_zero_peak
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_scaled) && $stable(o_zero_peak)))
        else $error("output transaction changed while stalled");

    a_zero_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_peak) |-> (o_scaled == '0))
        else $error("zero peak with nonzero result");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

endmodule

bind audio_peak_normalizer apn_checker u_apn_checker (.*);
